// ===== sv/srcmd_pkg.sv =====
// Shared types, sizes and codes for the source-to-memory-domain lookup block.
// Used by the front end, the back end and the top level; depends on nothing.
`timescale 1ns / 1ps

package srcmd_pkg;

  // table sizes
  localparam int unsigned REQUESTER_COUNT = 64;
  localparam int unsigned DOMAIN_SLOTS    = 63;
  localparam int unsigned REQ_AW          = $clog2(REQUESTER_COUNT);
  localparam int unsigned DOM_AW          = $clog2(DOMAIN_SLOTS);

  // field widths
  localparam int unsigned KIND_W     = 3;
  localparam int unsigned ID_W       = 6;
  localparam int unsigned ACC_W      = 2;
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned MAP_W      = 63;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 6;

  // requester ranges of the permission tables
  localparam int unsigned PERM_LOW_REQS = 16;
  localparam int unsigned PERM_REQS     = 32;

  // command queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // item kind codes
  localparam logic [KIND_W-1:0] KIND_WR_ENL  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_WR_ENH  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_WR_PL   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_WR_PH   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_LOOKUP  = 3'd4;
  localparam logic [KIND_W-1:0] KIND_CHECK   = 3'd5;

  // table format codes
  localparam logic [1:0] FMT_BITMAP  = 2'd0;
  localparam logic [1:0] FMT_COMPACT = 2'd1;
  localparam logic [1:0] FMT_DOMAIN  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_FORMAT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MD_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_ENH      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_PERMH    = 2'd3;

  typedef enum logic [2:0] {
    OP_WR_ENL = 3'd0,
    OP_WR_ENH = 3'd1,
    OP_WR_PL  = 3'd2,
    OP_WR_PH  = 3'd3,
    OP_LOOKUP = 3'd4,
    OP_CHECK  = 3'd5
  } op_e;

  typedef enum logic [ACC_W-1:0] {
    ACC_READ   = 2'd0,
    ACC_WRITE  = 2'd1,
    ACC_FETCH  = 2'd2,
    ACC_ATOMIC = 2'd3
  } acc_e;

  typedef struct packed {
    logic [1:0]      fmt;
    logic [ID_W-1:0] md_count;
    logic            enh;
    logic            permh;
  } cfg_t;

  // classified command as it travels through the queue
  typedef struct packed {
    op_e               op;
    logic [ID_W-1:0]   req;
    logic [ID_W-1:0]   dom;
    acc_e              acc;
    logic [WORD_W-1:0] word;
    logic              req_ok;   // requester has enable rows
    logic              dom_ok;   // domain has a permission slot
    logic              perm_ok;  // requester has a permission pair
    logic              perm_hi;  // pair lives in the high permission table
  } cmd_t;

endpackage

// ===== sv/srcmd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package needed.
`timescale 1ns / 1ps

module srcmd_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write one entry, read one entry per cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/srcmd_front.sv =====
// Front end: accepts items, classifies them into commands and queues them.
// Depends on srcmd_pkg.
`timescale 1ns / 1ps

module srcmd_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [srcmd_pkg::KIND_W-1:0]  kind_i,
  input  logic [srcmd_pkg::ID_W-1:0]    requester_i,
  input  logic [srcmd_pkg::ID_W-1:0]    domain_i,
  input  logic [srcmd_pkg::ACC_W-1:0]   access_type_i,
  input  logic [srcmd_pkg::WORD_W-1:0]  write_word_i,
  input  srcmd_pkg::cfg_t               cfg_i,
  input  logic                          pop_i,
  output logic                          cmd_valid_o,
  output srcmd_pkg::cmd_t               cmd_o
);
  import srcmd_pkg::*;

  cmd_t              cls;
  logic              keep;
  logic              push;
  cmd_t              q_mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;

  // classify the incoming item and flag out-of-range indexes
  always_comb begin
    cls.req     = requester_i;
    cls.dom     = domain_i;
    cls.acc     = acc_e'(access_type_i);
    cls.word    = write_word_i;
    cls.req_ok  = {1'b0, requester_i} < (ID_W + 1)'(REQUESTER_COUNT);
    cls.dom_ok  = {1'b0, domain_i} < (ID_W + 1)'(DOMAIN_SLOTS);
    cls.perm_hi = {1'b0, requester_i} >= (ID_W + 1)'(PERM_LOW_REQS);
    cls.perm_ok = ({1'b0, requester_i} < (ID_W + 1)'(PERM_LOW_REQS)) ||
                  (({1'b0, requester_i} < (ID_W + 1)'(PERM_REQS)) && cfg_i.permh);
    cls.op      = OP_LOOKUP;
    keep        = 1'b0;
    case (kind_i)
      KIND_WR_ENL: begin
        cls.op = OP_WR_ENL;
        keep   = cls.req_ok;
      end
      KIND_WR_ENH: begin
        cls.op = OP_WR_ENH;
        keep   = cls.req_ok;
      end
      KIND_WR_PL: begin
        cls.op = OP_WR_PL;
        keep   = cls.dom_ok;
      end
      KIND_WR_PH: begin
        cls.op = OP_WR_PH;
        keep   = cls.dom_ok;
      end
      KIND_LOOKUP: begin
        cls.op = OP_LOOKUP;
        keep   = 1'b1;
      end
      KIND_CHECK: begin
        cls.op = OP_CHECK;
        keep   = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  // hold off new items while the queue is full; drop items with no effect
  assign busy = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign push = start && !busy && keep;

  // advance queue pointers and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push, pop_i})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // store the command payload
  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_ptr_q] <= cls;
    end
  end

  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = q_mem_q[rd_ptr_q];

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCNT_W'(QUEUE_DEPTH))
    else $error("command queue count overflow");
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> cnt_q != '0)
    else $error("pop from empty command queue");
`endif

endmodule

// ===== sv/srcmd_back.sv =====
// Back end: owns the enable and permission tables and executes commands.
// Depends on srcmd_pkg and srcmd_ram.
`timescale 1ns / 1ps

module srcmd_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  srcmd_pkg::cfg_t               cfg_i,
  input  logic                          cmd_valid_i,
  input  srcmd_pkg::cmd_t               cmd_i,
  output logic                          pop_o,
  output logic                          done_o,
  output logic [srcmd_pkg::MAP_W-1:0]   domain_bitmap_o,
  output logic                          permitted_o
);
  import srcmd_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_LOOK  = 4'b0010,
    ST_CHECK = 4'b0100,
    ST_SCAN  = 4'b1000
  } state_e;

  state_e              st_q, st_d;
  cmd_t                cur_q, cur_d;
  logic [DOM_AW-1:0]   idx_q, idx_d;
  logic [MAP_W-1:0]    map_q, map_d;
  logic                done_q, done_d;
  logic [MAP_W-1:0]    bitmap_q, bitmap_d;
  logic                perm_q, perm_d;

  logic enl_we, enh_we, pl_we, ph_we;
  logic [REQ_AW-1:0] en_raddr;
  logic [DOM_AW-1:0] pm_raddr;
  logic [WORD_W-1:0] enl_rdata, enh_rdata, pl_rdata, ph_rdata;

  logic [REQUESTER_COUNT-1:0] enl_vld_q, enh_vld_q;
  logic [DOMAIN_SLOTS-1:0]    pl_vld_q, ph_vld_q;
  logic enl_rv_q, enh_rv_q, pl_rv_q, ph_rv_q;

  logic [WORD_W-1:0] enl_word, enh_word, pm_word;
  logic [1:0]        pair;
  logic [ID_W:0]     scan_lim;
  logic [ID_W:0]     next_idx;
  logic [MAP_W-1:0]  map_hit;
  logic              compact_hit;

  // tables
  srcmd_ram #(.WIDTH(WORD_W), .DEPTH(REQUESTER_COUNT)) u_enl_ram (
    .clk_i   (clk_i),
    .we_i    (enl_we),
    .waddr_i (cmd_i.req[REQ_AW-1:0]),
    .wdata_i (cmd_i.word),
    .raddr_i (en_raddr),
    .rdata_o (enl_rdata)
  );

  srcmd_ram #(.WIDTH(WORD_W), .DEPTH(REQUESTER_COUNT)) u_enh_ram (
    .clk_i   (clk_i),
    .we_i    (enh_we),
    .waddr_i (cmd_i.req[REQ_AW-1:0]),
    .wdata_i (cmd_i.word),
    .raddr_i (en_raddr),
    .rdata_o (enh_rdata)
  );

  srcmd_ram #(.WIDTH(WORD_W), .DEPTH(DOMAIN_SLOTS)) u_pl_ram (
    .clk_i   (clk_i),
    .we_i    (pl_we),
    .waddr_i (cmd_i.dom[DOM_AW-1:0]),
    .wdata_i (cmd_i.word),
    .raddr_i (pm_raddr),
    .rdata_o (pl_rdata)
  );

  srcmd_ram #(.WIDTH(WORD_W), .DEPTH(DOMAIN_SLOTS)) u_ph_ram (
    .clk_i   (clk_i),
    .we_i    (ph_we),
    .waddr_i (cmd_i.dom[DOM_AW-1:0]),
    .wdata_i (cmd_i.word),
    .raddr_i (pm_raddr),
    .rdata_o (ph_rdata)
  );

  // mask entries never written since reset
  assign enl_word = enl_rv_q ? enl_rdata : '0;
  assign enh_word = enh_rv_q ? enh_rdata : '0;
  assign pm_word  = cur_q.perm_hi ? (ph_rv_q ? ph_rdata : '0) : (pl_rv_q ? pl_rdata : '0);

  // read/write pair of the current requester
  assign pair = 2'(pm_word >> {cur_q.req[3:0], 1'b0});

  assign scan_lim = ({1'b0, cfg_i.md_count} < (ID_W + 1)'(DOMAIN_SLOTS)) ?
                    {1'b0, cfg_i.md_count} : (ID_W + 1)'(DOMAIN_SLOTS);
  assign next_idx = (ID_W + 1)'(idx_q) + 1'b1;
  assign map_hit  = map_q | (MAP_W'(pair != 2'b00) << idx_q);
  assign compact_hit = ({1'b0, cmd_i.req} < {1'b0, cfg_i.md_count}) &&
                       ({1'b0, cmd_i.req} < (ID_W + 1)'(MAP_W));

  // sequence one command at a time
  always_comb begin
    st_d     = st_q;
    cur_d    = cur_q;
    idx_d    = idx_q;
    map_d    = map_q;
    done_d   = 1'b0;
    bitmap_d = bitmap_q;
    perm_d   = perm_q;
    pop_o    = 1'b0;
    enl_we   = 1'b0;
    enh_we   = 1'b0;
    pl_we    = 1'b0;
    ph_we    = 1'b0;
    en_raddr = cmd_i.req[REQ_AW-1:0];
    pm_raddr = cmd_i.dom[DOM_AW-1:0];
    case (st_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          pop_o = 1'b1;
          cur_d = cmd_i;
          case (cmd_i.op)
            OP_WR_ENL: enl_we = 1'b1;
            OP_WR_ENH: enh_we = 1'b1;
            OP_WR_PL:  pl_we  = 1'b1;
            OP_WR_PH:  ph_we  = 1'b1;
            OP_LOOKUP: begin
              if (!cmd_i.req_ok) begin
                done_d   = 1'b1;
                bitmap_d = '0;
                perm_d   = 1'b0;
              end else if (cfg_i.fmt == FMT_COMPACT) begin
                done_d   = 1'b1;
                bitmap_d = compact_hit ? (MAP_W'(1) << cmd_i.req) : '0;
                perm_d   = 1'b0;
              end else if (cfg_i.fmt == FMT_DOMAIN) begin
                if (!cmd_i.perm_ok || scan_lim == '0) begin
                  done_d   = 1'b1;
                  bitmap_d = '0;
                  perm_d   = 1'b0;
                end else begin
                  pm_raddr = '0;
                  idx_d    = '0;
                  map_d    = '0;
                  st_d     = ST_SCAN;
                end
              end else begin
                st_d = ST_LOOK;
              end
            end
            OP_CHECK: begin
              if (cmd_i.perm_ok && cmd_i.dom_ok) begin
                st_d = ST_CHECK;
              end else begin
                done_d   = 1'b1;
                bitmap_d = '0;
                perm_d   = 1'b0;
              end
            end
            default: ;
          endcase
        end
      end
      ST_LOOK: begin
        done_d   = 1'b1;
        bitmap_d = {(cfg_i.enh ? enh_word : '0), enl_word[WORD_W-1:1]};
        perm_d   = 1'b0;
        st_d     = ST_IDLE;
      end
      ST_CHECK: begin
        done_d   = 1'b1;
        bitmap_d = '0;
        case (cur_q.acc)
          ACC_READ:   perm_d = pair[0];
          ACC_WRITE:  perm_d = pair[1];
          ACC_FETCH:  perm_d = pair[0];
          ACC_ATOMIC: perm_d = &pair;
          default:    perm_d = 1'b0;
        endcase
        st_d = ST_IDLE;
      end
      ST_SCAN: begin
        // merge the returning slot, fetch the next one
        if (next_idx < scan_lim) begin
          map_d    = map_hit;
          idx_d    = next_idx[DOM_AW-1:0];
          pm_raddr = next_idx[DOM_AW-1:0];
        end else begin
          done_d   = 1'b1;
          bitmap_d = map_hit;
          perm_d   = 1'b0;
          st_d     = ST_IDLE;
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= ST_IDLE;
      done_q    <= 1'b0;
      enl_vld_q <= '0;
      enh_vld_q <= '0;
      pl_vld_q  <= '0;
      ph_vld_q  <= '0;
      enl_rv_q  <= 1'b0;
      enh_rv_q  <= 1'b0;
      pl_rv_q   <= 1'b0;
      ph_rv_q   <= 1'b0;
    end else begin
      st_q   <= st_d;
      done_q <= done_d;
      // mark written entries
      if (enl_we) enl_vld_q[cmd_i.req[REQ_AW-1:0]] <= 1'b1;
      if (enh_we) enh_vld_q[cmd_i.req[REQ_AW-1:0]] <= 1'b1;
      if (pl_we)  pl_vld_q[cmd_i.dom[DOM_AW-1:0]]  <= 1'b1;
      if (ph_we)  ph_vld_q[cmd_i.dom[DOM_AW-1:0]]  <= 1'b1;
      // sample valid bits alongside the registered read
      enl_rv_q <= enl_vld_q[en_raddr];
      enh_rv_q <= enh_vld_q[en_raddr];
      if ({1'b0, pm_raddr} < (DOM_AW + 1)'(DOMAIN_SLOTS)) begin
        pl_rv_q <= pl_vld_q[pm_raddr];
        ph_rv_q <= ph_vld_q[pm_raddr];
      end else begin
        pl_rv_q <= 1'b0;
        ph_rv_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cur_q    <= cur_d;
    idx_q    <= idx_d;
    map_q    <= map_d;
    bitmap_q <= bitmap_d;
    perm_q   <= perm_d;
  end

  assign done_o          = done_q;
  assign domain_bitmap_o = bitmap_q;
  assign permitted_o     = perm_q;

`ifndef NO_ASSERTIONS
  a_scan_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == ST_SCAN |-> cur_q.op == OP_LOOKUP && cur_q.perm_ok)
    else $error("domain scan without a permitted lookup");
  a_single_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_LOOK || st_q == ST_CHECK) |=> done_q && st_q == ST_IDLE)
    else $error("lookup or check did not finish in one step");
`endif

endmodule

// ===== sv/srcmd_domain_lookup.sv =====
// Top level of the source-to-memory-domain lookup block: configuration
// registers, front end and back end. Depends on srcmd_pkg, srcmd_front, srcmd_back.
//
// Use: an item is taken when start is high and busy is low. Write kinds
// store one table word and give no result; lookup and check give one
// result, shown for one cycle on domain_bitmap_o / permitted_o with done_o.
// Results come in item order and the receiver must take them as they come.
// A compact lookup or a rejected lookup/check is answered from the idle
// state of the back end, a bitmap lookup or a check from its look or check
// state, and a domain-indexed lookup from its scan state (one permission
// slot per cycle through the permission RAM read port); the result is
// registered. The back end finishes one write per cycle; its look, check
// and scan states hold later commands in a 2-entry command queue that absorbs
// bursts, and busy rises when it is full. Kinds 6 and 7 are taken and dropped.
// Configuration writes are registered and must be made only while idle; nothing enforces it.
// Reset restores the register defaults and marks every table entry unwritten,
// so all tables read as zero without a clearing pass.
`timescale 1ns / 1ps

module srcmd_domain_lookup (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  logic [srcmd_pkg::KIND_W-1:0]     kind_i,
  input  logic [srcmd_pkg::ID_W-1:0]       requester_i,
  input  logic [srcmd_pkg::ID_W-1:0]       domain_i,
  input  logic [srcmd_pkg::ACC_W-1:0]      access_type_i,
  input  logic [srcmd_pkg::WORD_W-1:0]     write_word_i,
  input  logic                             cfg_we_i,
  input  logic [srcmd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [srcmd_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output logic                             done_o,
  output logic [srcmd_pkg::MAP_W-1:0]      domain_bitmap_o,
  output logic                             permitted_o
);
  import srcmd_pkg::*;

  cfg_t cfg_q, cfg_d;
  logic cmd_valid;
  cmd_t cmd;
  logic pop;

  // configuration register writes
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_IDX_FORMAT:   cfg_d.fmt      = cfg_data_i[1:0];
        CFG_IDX_MD_COUNT: cfg_d.md_count = cfg_data_i[ID_W-1:0];
        CFG_IDX_ENH:      cfg_d.enh      = cfg_data_i[0];
        CFG_IDX_PERMH:    cfg_d.permh    = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fmt      <= FMT_BITMAP;
      cfg_q.md_count <= ID_W'(MAP_W);
      cfg_q.enh      <= 1'b1;
      cfg_q.permh    <= 1'b1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  srcmd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .kind_i        (kind_i),
    .requester_i   (requester_i),
    .domain_i      (domain_i),
    .access_type_i (access_type_i),
    .write_word_i  (write_word_i),
    .cfg_i         (cfg_q),
    .pop_i         (pop),
    .cmd_valid_o   (cmd_valid),
    .cmd_o         (cmd)
  );

  srcmd_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .cmd_valid_i     (cmd_valid),
    .cmd_i           (cmd),
    .pop_o           (pop),
    .done_o          (done_o),
    .domain_bitmap_o (domain_bitmap_o),
    .permitted_o     (permitted_o)
  );

endmodule

// ===== bench/tb_srcmd_domain_lookup.sv =====
// Self-checking bench for srcmd_domain_lookup: table writes, lookups and checks
// over many table settings, predicted by a scoreboard class; uses srcmd_pkg, the DUT.
`timescale 1ns / 1ps

module tb_srcmd_domain_lookup;
  import srcmd_pkg::*;

  localparam int unsigned PHASES      = 14;
  localparam int unsigned PHASE_ITEMS = 111;
  localparam int unsigned SETTLE      = 24;
  localparam int unsigned TAIL        = 100;

  typedef struct {
    logic [MAP_W-1:0] bitmap;
    logic             permitted;
  } result_t;

  // Mirror of the tables and registers; predicts one result per lookup or check.
  class domain_map_tracker;
    logic [WORD_W-1:0] en_lo   [REQUESTER_COUNT];
    logic [WORD_W-1:0] en_hi   [REQUESTER_COUNT];
    logic [WORD_W-1:0] perm_lo [DOMAIN_SLOTS];
    logic [WORD_W-1:0] perm_hi [DOMAIN_SLOTS];
    logic [1:0]        fmt;
    logic [ID_W-1:0]   md_count;
    logic              enh;
    logic              permh;
    result_t           awaited_results[$];
    int unsigned       errors;
    int unsigned       checked;

    function new();
      foreach (en_lo[i]) begin
        en_lo[i] = '0;
        en_hi[i] = '0;
      end
      foreach (perm_lo[i]) begin
        perm_lo[i] = '0;
        perm_hi[i] = '0;
      end
      fmt      = FMT_BITMAP;
      md_count = 6'd63;
      enh      = 1'b1;
      permh    = 1'b1;
      errors   = 0;
      checked  = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_IDX_FORMAT:   fmt      = data[1:0];
        CFG_IDX_MD_COUNT: md_count = data[ID_W-1:0];
        CFG_IDX_ENH:      enh      = data[0];
        default:          permh    = data[0];
      endcase
    endfunction

    // Fetch the read/write pair; zero return when the requester has no pair or the domain no slot.
    function bit perm_pair(int unsigned req, int unsigned dom, output logic [1:0] pair);
      logic [WORD_W-1:0] w;
      int unsigned       pos;
      pair = 2'b00;
      if (dom >= DOMAIN_SLOTS) return 1'b0;
      if (req < PERM_LOW_REQS) begin
        w   = perm_lo[dom];
        pos = 2 * req;
      end else if (req < PERM_REQS && permh) begin
        w   = perm_hi[dom];
        pos = 2 * (req - PERM_LOW_REQS);
      end else begin
        return 1'b0;
      end
      pair = w[pos +: 2];
      return 1'b1;
    endfunction

    function logic [MAP_W-1:0] predict_bitmap(int unsigned req);
      logic [MAP_W-1:0] m;
      logic [1:0]       pair;
      m = '0;
      if (fmt == FMT_COMPACT) begin
        if (req < md_count && req < MAP_W) m[req] = 1'b1;
      end else if (fmt == FMT_DOMAIN) begin
        for (int unsigned d = 0; d < md_count && d < DOMAIN_SLOTS; d++)
          if (perm_pair(req, d, pair) && pair != 2'b00) m[d] = 1'b1;
      end else begin
        // bitmap format, and format code 3 acts the same
        m = MAP_W'(en_lo[req] >> 1);
        if (enh) m = m | {en_hi[req], 31'b0};
      end
      return m;
    endfunction

    function logic predict_grant(int unsigned req, int unsigned dom, logic [ACC_W-1:0] acc);
      logic [1:0] pair;
      if (!perm_pair(req, dom, pair)) return 1'b0;
      case (acc)
        ACC_READ, ACC_FETCH: return pair[0];
        ACC_WRITE:           return pair[1];
        default:             return pair == 2'b11;
      endcase
    endfunction

    // Update the mirror with an accepted item and queue its result, if any.
    function void take_item(logic [KIND_W-1:0] kind, logic [ID_W-1:0] req,
                            logic [ID_W-1:0] dom, logic [ACC_W-1:0] acc,
                            logic [WORD_W-1:0] word);
      result_t r;
      case (kind)
        KIND_WR_ENL: en_lo[req] = word;
        KIND_WR_ENH: en_hi[req] = word;
        KIND_WR_PL:  if (dom < DOMAIN_SLOTS) perm_lo[dom] = word;
        KIND_WR_PH:  if (dom < DOMAIN_SLOTS) perm_hi[dom] = word;
        KIND_LOOKUP: begin
          r.bitmap    = predict_bitmap(req);
          r.permitted = 1'b0;
          awaited_results.push_back(r);
        end
        KIND_CHECK: begin
          r.bitmap    = '0;
          r.permitted = predict_grant(req, dom, acc);
          awaited_results.push_back(r);
        end
        default: ;
      endcase
    endfunction

    function void match_result(logic [MAP_W-1:0] bitmap, logic permitted);
      result_t r;
      if (awaited_results.size() == 0) begin
        $error("result with nothing outstanding: bitmap %h permitted %b", bitmap, permitted);
        errors++;
        return;
      end
      r = awaited_results.pop_front();
      checked++;
      if (bitmap !== r.bitmap) begin
        $error("domain_bitmap: expected %h, actual %h", r.bitmap, bitmap);
        errors++;
      end
      if (permitted !== r.permitted) begin
        $error("permitted: expected %b, actual %b", r.permitted, permitted);
        errors++;
      end
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  start;
  logic                  busy;
  logic [KIND_W-1:0]     kind_i;
  logic [ID_W-1:0]       requester_i;
  logic [ID_W-1:0]       domain_i;
  logic [ACC_W-1:0]      access_type_i;
  logic [WORD_W-1:0]     write_word_i;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  done_o;
  logic [MAP_W-1:0]      domain_bitmap_o;
  logic                  permitted_o;

  domain_map_tracker tracker = new();
  int unsigned       items_sent;
  bit                steady;

  srcmd_domain_lookup DUT (
    .clk_i,
    .rst_ni,
    .start,
    .busy,
    .kind_i,
    .requester_i,
    .domain_i,
    .access_type_i,
    .write_word_i,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .done_o,
    .domain_bitmap_o,
    .permitted_o
  );

  always #1 clk_i = ~clk_i;

  // Compare every strobed result against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) tracker.match_result(domain_bitmap_o, permitted_o);
  end

  // Hold start and the fields until the item is taken; start stays high after unless idle_gap drops it.
  task automatic send_item(logic [KIND_W-1:0] kind, logic [ID_W-1:0] req,
                           logic [ID_W-1:0] dom, logic [ACC_W-1:0] acc,
                           logic [WORD_W-1:0] word);
    start         <= 1'b1;
    kind_i        <= kind;
    requester_i   <= req;
    domain_i      <= dom;
    access_type_i <= acc;
    write_word_i  <= word;
    do @(posedge clk_i); while (busy);
    tracker.take_item(kind, req, dom, acc, word);
    items_sent++;
    idle_gap();
  endtask

  // Maybe drop start for a random number of cycles, mostly short, now and then long.
  task automatic idle_gap();
    int unsigned pick;
    int unsigned n;
    pick = $urandom_range(99);
    if (steady || pick < 55) return;
    n = (pick < 92) ? $urandom_range(3, 1) : $urandom_range(40, 8);
    start <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // Wait for every outstanding result, then let trailing writes finish.
  task automatic drain();
    start <= 1'b0;
    while (tracker.awaited_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // Write all four registers in back-to-back cycles.
  task automatic apply_config(logic [1:0] fmt, logic [ID_W-1:0] md,
                              logic enh, logic permh);
    logic [CFG_IDX_W-1:0]  idx [4];
    logic [CFG_DATA_W-1:0] val [4];
    idx = '{CFG_IDX_FORMAT, CFG_IDX_MD_COUNT, CFG_IDX_ENH, CFG_IDX_PERMH};
    val = '{CFG_DATA_W'(fmt), CFG_DATA_W'(md), CFG_DATA_W'(enh), CFG_DATA_W'(permh)};
    for (int i = 0; i < 4; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= idx[i];
      cfg_data_i <= val[i];
      @(posedge clk_i);
      tracker.set_reg(idx[i], val[i]);
    end
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [WORD_W-1:0] rand_word();
    case ($urandom_range(3))
      0:       return $urandom;
      1:       return $urandom & $urandom & $urandom;
      2:       return $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
      default: return $urandom | $urandom;
    endcase
  endfunction

  // A random mix of table fills, lookups and checks, plus a little noise.
  task automatic random_item();
    int unsigned       pick;
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   req;
    logic [ID_W-1:0]   dom;
    pick = $urandom_range(99);
    if (pick < 12)      kind = KIND_WR_ENL;
    else if (pick < 22) kind = KIND_WR_ENH;
    else if (pick < 32) kind = KIND_WR_PL;
    else if (pick < 40) kind = KIND_WR_PH;
    else if (pick < 70) kind = KIND_LOOKUP;
    else if (pick < 96) kind = KIND_CHECK;
    else                kind = KIND_W'($urandom_range(7, 6));
    req = ($urandom_range(9) < 6) ? ID_W'($urandom_range(31)) : ID_W'($urandom_range(63));
    dom = ($urandom_range(19) == 0) ? ID_W'($urandom_range(63)) : ID_W'($urandom_range(62));
    send_item(kind, req, dom, ACC_W'($urandom_range(3)), rand_word());
  endtask

  initial begin
    logic [1:0]      fmts   [10];
    logic [ID_W-1:0] counts [10];
    logic            enhs   [10];
    logic            permhs [10];
    fmts   = '{FMT_BITMAP, FMT_BITMAP, FMT_COMPACT, FMT_COMPACT, FMT_DOMAIN,
               FMT_DOMAIN, FMT_DOMAIN, 2'd3, FMT_DOMAIN, FMT_COMPACT};
    counts = '{6'd63, 6'd63, 6'd63, 6'd0, 6'd63, 6'd0, 6'd1, 6'd63, 6'd17, 6'd31};
    enhs   = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
    permhs = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1};
    items_sent = 0;
    steady     = 1'b0;
    rst_ni        <= 1'b0;
    start         <= 1'b0;
    kind_i        <= '0;
    requester_i   <= '0;
    domain_i      <= '0;
    access_type_i <= '0;
    write_word_i  <= '0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= '0;
    cfg_data_i    <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: cleared tables, full and edge words, all access types, ignored cases.
    send_item(KIND_LOOKUP, 6'd0,  6'd0,  ACC_READ,   32'h0);
    send_item(KIND_CHECK,  6'd0,  6'd0,  ACC_READ,   32'h0);
    send_item(KIND_WR_ENL, 6'd0,  6'd0,  ACC_READ,   32'hFFFF_FFFF);
    send_item(KIND_WR_ENH, 6'd0,  6'd0,  ACC_READ,   32'hFFFF_FFFF);
    send_item(KIND_LOOKUP, 6'd0,  6'd0,  ACC_READ,   32'h0);
    send_item(KIND_WR_ENL, 6'd63, 6'd0,  ACC_READ,   32'h0000_0001);
    send_item(KIND_WR_ENH, 6'd63, 6'd0,  ACC_READ,   32'h8000_0000);
    send_item(KIND_LOOKUP, 6'd63, 6'd63, ACC_ATOMIC, 32'h0);
    send_item(KIND_WR_PL,  6'd0,  6'd0,  ACC_READ,   32'hFFFF_FFFF);
    send_item(KIND_WR_PH,  6'd0,  6'd62, ACC_READ,   32'hAAAA_AAAA);
    send_item(KIND_WR_PL,  6'd0,  6'd63, ACC_READ,   32'hFFFF_FFFF);
    send_item(KIND_WR_PH,  6'd0,  6'd63, ACC_READ,   32'hFFFF_FFFF);
    send_item(KIND_CHECK,  6'd0,  6'd0,  ACC_READ,   32'h0);
    send_item(KIND_CHECK,  6'd0,  6'd0,  ACC_WRITE,  32'h0);
    send_item(KIND_CHECK,  6'd0,  6'd0,  ACC_FETCH,  32'h0);
    send_item(KIND_CHECK,  6'd0,  6'd0,  ACC_ATOMIC, 32'h0);
    send_item(KIND_CHECK,  6'd31, 6'd62, ACC_READ,   32'h0);
    send_item(KIND_CHECK,  6'd31, 6'd62, ACC_WRITE,  32'h0);
    send_item(KIND_CHECK,  6'd31, 6'd62, ACC_ATOMIC, 32'h0);
    send_item(KIND_CHECK,  6'd15, 6'd63, ACC_READ,   32'h0);
    send_item(KIND_CHECK,  6'd32, 6'd0,  ACC_READ,   32'h0);
    send_item(3'd6,        6'd1,  6'd1,  ACC_READ,   32'h1234_5678);
    send_item(3'd7,        6'd0,  6'd0,  ACC_READ,   32'hFFFF_FFFF);
    send_item(KIND_LOOKUP, 6'd0,  6'd0,  ACC_READ,   32'h0);

    // Random phases: fixed corner settings first, then random settings.
    for (int unsigned p = 0; p < PHASES; p++) begin
      drain();
      if (p < 10) apply_config(fmts[p], counts[p], enhs[p], permhs[p]);
      else apply_config(2'($urandom_range(3)), ID_W'($urandom_range(63)),
                        1'($urandom_range(1)), 1'($urandom_range(1)));
      steady = ($urandom_range(3) == 0);
      for (int unsigned n = 0; n < PHASE_ITEMS; n++) random_item();
    end

    drain();
    repeat (TAIL) @(posedge clk_i);
    $display("Sent %0d items over %0d table settings; checked %0d lookup and check results.",
             items_sent, PHASES + 1, tracker.checked);
    if (tracker.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Stop a hung run.
  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== files.f =====
sv/srcmd_pkg.sv
sv/srcmd_ram.sv
sv/srcmd_front.sv
sv/srcmd_back.sv
sv/srcmd_domain_lookup.sv
bench/tb_srcmd_domain_lookup.sv
